/* rtl/cws_pkg.sv */
// Shared definitions for the comment and whitespace stripper.
// Holds the scan mode type, the character codes and the whitespace test.
// No dependencies.
`default_nettype none

package cws_pkg;

    // Scan modes of the stripper
    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE_CMT   = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4
    } scan_mode_t;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_VTAB    = 8'h0B;
    localparam logic [7:0] CHAR_FFEED   = 8'h0C;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    // Space, tab, newline, vertical tab, form feed and carriage return.
    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE) ||
                   (c == CHAR_VTAB) || (c == CHAR_FFEED) || (c == CHAR_CR);
    endfunction

endpackage

`default_nettype wire

/* rtl/comment_whitespace_stripper.sv */
// Top level of the comment and whitespace stripper.
// Holds the scanner state and result decode; results queue in cws_fifo.
// Depends on cws_pkg and cws_fifo.
//
//  Channel   Direction  tdata                                  tuser / tlast
//  s_axis    in         char_code                              -
//  m_axis    out        out_char, line_number, column_number   gap_before, end_of_text / last
//
// One source byte is taken per cycle; each byte is decoded in the cycle it is
// accepted and its zero, one or two results are written into a four-entry
// queue, from which one result beat leaves per cycle while m_axis is ready. A
// byte that yields two results (a flushed slash) takes two output beats. Input
// is taken while the queue has room for two results. Reset puts the scanner at
// line 1, column 1 in normal mode and empties the queue.
`default_nettype none

module comment_whitespace_stripper
    import cws_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    // out_char, then line_number, then column_number, zero filled to bytes
    output logic [((8 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [1:0]      m_axis_tuser,   // [0] gap_before, [1] end_of_text
    output logic            m_axis_tlast
);

    localparam int TDATA_W = ((8 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8;
    localparam int ENTRY_W = 8 + LINE_BITS + COLUMN_BITS + 3;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    // Scanner state
    scan_mode_t             mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   held_line_reg, held_line_next;
    logic [COLUMN_BITS-1:0] held_col_reg, held_col_next;
    logic                   gap_reg, gap_next;
    logic                   held_gap_reg, held_gap_next;

    logic                   accept;
    logic [7:0]             c;
    logic                   c_space;
    logic [LINE_BITS-1:0]   adv_line;
    logic [COLUMN_BITS-1:0] adv_col;

    // Result decode
    logic [1:0]             res_count;
    logic [7:0]             r0_char, r1_char;
    logic [LINE_BITS-1:0]   r0_line, r1_line;
    logic [COLUMN_BITS-1:0] r0_col, r1_col;
    logic                   r0_gap, r1_gap;
    logic                   r0_eot, r1_eot;
    logic [ENTRY_W-1:0]     entry0, entry1, head;
    logic                   fifo_room;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign c       = s_axis_tdata;
    assign c_space = is_space(c);

    // Position after this byte, both counters saturating.
    always_comb
    begin
        adv_line = line_reg;
        adv_col  = col_reg;
        if (c == CHAR_NEWLINE)
        begin
            if (line_reg != LINE_MAX)
            begin
                adv_line = line_reg + LINE_ONE;
            end
            adv_col = COL_ONE;
        end
        else if (col_reg != COL_MAX)
        begin
            adv_col = col_reg + COL_ONE;
        end
    end

    // Next scanner state.
    always_comb
    begin
        mode_next      = mode_reg;
        line_next      = adv_line;
        col_next       = adv_col;
        held_line_next = held_line_reg;
        held_col_next  = held_col_reg;
        gap_next       = gap_reg;
        held_gap_next  = held_gap_reg;
        if (c == CHAR_NUL)
        begin
            // End of text: everything returns to its reset value.
            mode_next      = MODE_NORMAL;
            line_next      = LINE_ONE;
            col_next       = COL_ONE;
            held_line_next = LINE_ONE;
            held_col_next  = COL_ONE;
            gap_next       = 1'b0;
            held_gap_next  = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if (c == CHAR_SLASH)
                    begin
                        mode_next = MODE_LINE_CMT;
                        gap_next  = 1'b1;
                    end
                    else if (c == CHAR_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                        gap_next  = 1'b1;
                    end
                    else
                    begin
                        // Held slash is flushed; byte is then handled as normal.
                        mode_next = MODE_NORMAL;
                        gap_next  = c_space;
                    end
                end
                MODE_LINE_CMT:
                begin
                    if (c == CHAR_NEWLINE)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_BLOCK:
                begin
                    if (c == CHAR_STAR)
                    begin
                        mode_next = MODE_BLOCK_STAR;
                    end
                end
                MODE_BLOCK_STAR:
                begin
                    if (c == CHAR_SLASH)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (c != CHAR_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    if (c_space)
                    begin
                        gap_next = 1'b1;
                    end
                    else if (c == CHAR_SLASH)
                    begin
                        held_line_next = line_reg;
                        held_col_next  = col_reg;
                        held_gap_next  = gap_reg;
                        gap_next       = 1'b0;
                        mode_next      = MODE_SLASH;
                    end
                    else
                    begin
                        gap_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            line_reg      <= LINE_ONE;
            col_reg       <= COL_ONE;
            held_line_reg <= LINE_ONE;
            held_col_reg  <= COL_ONE;
            gap_reg       <= 1'b0;
            held_gap_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            held_line_reg <= held_line_next;
            held_col_reg  <= held_col_next;
            gap_reg       <= gap_next;
            held_gap_reg  <= held_gap_next;
        end
    end

    // Results caused by this byte.
    always_comb
    begin
        res_count = 2'd0;
        r0_char   = c;
        r0_line   = line_reg;
        r0_col    = col_reg;
        r0_gap    = gap_reg;
        r0_eot    = 1'b0;
        r1_char   = c;
        r1_line   = line_reg;
        r1_col    = col_reg;
        r1_gap    = 1'b0;
        r1_eot    = 1'b0;
        if (c == CHAR_NUL)
        begin
            if (mode_reg == MODE_SLASH)
            begin
                // Flushed slash, then the end marker.
                res_count = 2'd2;
                r0_char   = CHAR_SLASH;
                r0_line   = held_line_reg;
                r0_col    = held_col_reg;
                r0_gap    = held_gap_reg;
                r1_char   = CHAR_NUL;
                r1_gap    = gap_reg;
                r1_eot    = 1'b1;
            end
            else
            begin
                res_count = 2'd1;
                r0_char   = CHAR_NUL;
                r0_eot    = 1'b1;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if (c != CHAR_SLASH && c != CHAR_STAR)
                    begin
                        r0_char = CHAR_SLASH;
                        r0_line = held_line_reg;
                        r0_col  = held_col_reg;
                        r0_gap  = held_gap_reg;
                        // An ordinary byte follows the slash without a gap.
                        res_count = c_space ? 2'd1 : 2'd2;
                    end
                end
                MODE_LINE_CMT, MODE_BLOCK, MODE_BLOCK_STAR:
                begin
                    res_count = 2'd0;
                end
                default:
                begin
                    if (!c_space && c != CHAR_SLASH)
                    begin
                        res_count = 2'd1;
                    end
                end
            endcase
        end
    end

    // Queue entries: {last, end_of_text, gap_before, column, line, char}.
    assign entry0 = {(res_count == 2'd1), r0_eot, r0_gap, r0_col, r0_line, r0_char};
    assign entry1 = {1'b1, r1_eot, r1_gap, r1_col, r1_line, r1_char};

    cws_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (accept ? res_count : 2'd0),
        .push_data0   (entry0),
        .push_data1   (entry1),
        .pop          (m_axis_tvalid && m_axis_tready),
        .head_data    (head),
        .not_empty    (m_axis_tvalid),
        .room_for_two (fifo_room)
    );

    assign s_axis_tready = fifo_room;

    // Output beat from the queue head.
    assign m_axis_tdata = TDATA_W'(head[8 + LINE_BITS + COLUMN_BITS - 1:0]);
    assign m_axis_tuser = head[ENTRY_W-2:ENTRY_W-3];
    assign m_axis_tlast = head[ENTRY_W-1];

endmodule

`default_nettype wire

/* rtl/cws_fifo.sv */
// Four-entry result queue for the comment and whitespace stripper.
// Takes up to two entries per cycle and gives one per cycle from the head while pop is high.
// Depends on no package.
`default_nettype none

module cws_fifo #(
    parameter int WIDTH = 39
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push_count,
    input  wire logic [WIDTH-1:0] push_data0,
    input  wire logic [WIDTH-1:0] push_data1,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  not_empty,
    output logic                  room_for_two
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W + 1)'(push_count) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage: first entry at the write pointer, second just after it.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push_data1;
        end
    end

    assign head_data    = entry_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= (PTR_W + 1)'(DEPTH - 2));

endmodule

`default_nettype wire
